/* rtl/core/arid_pkg.sv */
package arid_pkg;

    // one input transfer
    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_sample;
    } arid_in_t;

    // one result transfer
    typedef struct packed {
        logic       kind;
        logic [7:0] interval_left;
        logic [7:0] interval_right;
        logic [6:0] interval_score;
        logic [1:0] interval_group;
        logic [7:0] strength;
        logic       overflow;
        logic       last_result;
    } arid_out_t;

    localparam int unsigned MAX_LEN  = 256;
    localparam int unsigned ADDR_W   = 8;
    localparam int unsigned CNT_W    = 9;
    localparam int unsigned WIN_LEN  = 11;
    localparam int unsigned WIN_W    = 4;

    localparam logic [5:0] MAX_KEPT         = 6'd63;
    localparam logic [5:0] SPAN_FLOOR_RESET = 6'd5;
    localparam logic       KIND_INTERVAL    = 1'b0;
    localparam logic       KIND_STRENGTH    = 1'b1;
    localparam logic [0:0] REG_SPAN_FLOOR   = 1'b0;

endpackage

/* rtl/core/aroon_range_interval_detector.sv */
// aroon range-interval detector
//
// input channel (s_valid/s_ready/s_data): one signed sample per transfer, the
// sequence ends at a transfer with last_sample set. each stored sample is
// written, then the oscillator is worked out serially over the trailing
// 11-sample window before the next sample is taken.
// after the last sample the block walks the stored sequence from the sample
// and oscillator memories, running the score divider for each interval found
// and the strength divider at the end. the walk is bound by the single read
// port of the memories.
// result channel (m_valid/m_ready/m_data): one record per kept interval, then
// one strength record flagged last_result. results sit in an output register;
// while the receiver stalls the walk waits at the next record, and after the
// final record is loaded the block takes new samples at once.
// apb port: minimum span register at byte address 0, written with
// psel/penable/pwrite.
// reset (aresetn low, synchronous) empties the sequence, sets the minimum span
// to 5 and drops any pending result; the memories themselves are not cleared.
module aroon_range_interval_detector
    import arid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  arid_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output arid_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_OSC     = 4'd1;
    localparam logic [3:0] ST_FIN     = 4'd2;
    localparam logic [3:0] ST_SCAN_RD = 4'd3;
    localparam logic [3:0] ST_SCAN_EV = 4'd4;
    localparam logic [3:0] ST_SC_INIT = 4'd5;
    localparam logic [3:0] ST_SC_DIV  = 4'd6;
    localparam logic [3:0] ST_SC_SUM  = 4'd7;
    localparam logic [3:0] ST_SC_EMIT = 4'd8;
    localparam logic [3:0] ST_ST_INIT = 4'd9;
    localparam logic [3:0] ST_ST_DIV  = 4'd10;
    localparam logic [3:0] ST_ST_EMIT = 4'd11;

    // state memories: written while loading, read only during the walk, so
    // a read and a write of one entry never overlap
    logic signed [31:0] sample_mem [MAX_LEN];
    logic signed [7:0]  osc_mem    [MAX_LEN];

    logic [3:0]          state_reg;
    logic [5:0]          span_floor_reg;
    logic [CNT_W-1:0]    count_reg;
    logic signed [31:0]  seq_min_reg, seq_max_reg;
    logic [14:0]         sum_reg;
    logic                ovf_reg;
    logic                last_pend_reg;
    logic [5:0]          kept_reg;

    // trailing window, index 0 is the newest sample
    logic signed [31:0]  win_reg [WIN_LEN];
    logic [WIN_W-1:0]    osc_k_reg;
    logic                osc_first_reg;
    logic signed [31:0]  hi_v_reg, lo_v_reg;
    logic [WIN_W-1:0]    hi_a_reg, lo_a_reg;
    logic [ADDR_W-1:0]   wr_idx_reg;

    // walk
    logic [CNT_W-1:0]    i_reg;
    logic signed [31:0]  samp_q_reg;
    logic signed [7:0]   osc_q_reg;
    logic                in_run_reg;
    logic [ADDR_W-1:0]   left_reg, best_r_reg;
    logic signed [31:0]  run_min_reg, run_max_reg;
    logic [32:0]         best_d_reg;
    logic                best_ok_reg;
    logic                scan_done_reg;

    // shared restoring divider
    logic [39:0]         div_rem_reg;
    logic [7:0]          div_q_reg;
    logic [2:0]          div_bit_reg;
    logic [6:0]          score_reg;
    logic [7:0]          strength_reg;

    logic                m_valid_reg;
    arid_out_t           m_data_reg;

    logic [5:0]              mr;
    logic [32:0]             range_w;
    logic                    out_free;
    logic signed [31:0]      win_v;
    logic                    hi_upd, lo_upd;
    logic [WIN_W-1:0]        hi_a_n, lo_a_n;
    logic signed [4:0]       d_w;
    logic signed [7:0]       osc_w;
    logic                    rng;
    logic signed [31:0]      rmin_n, rmax_n;
    logic [ADDR_W-1:0]       left_n;
    logic [32:0]             spread_w;
    logic [35:0]             five_d;
    logic                    cand_ok;
    logic                    done_w;
    logic                    closing;
    logic                    best_ok_n;
    logic [39:0]             div_sub;
    logic                    div_ge;
    logic [7:0]              q_final;
    logic [ADDR_W-1:0]       len_w;
    logic [14:0]             prod_w;
    logic                    cfg_wr;

    assign mr       = (span_floor_reg == 6'd0) ? 6'd1 : span_floor_reg;
    assign range_w  = {seq_max_reg[31], seq_max_reg} - {seq_min_reg[31], seq_min_reg};
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_wr   = psel && penable && pwrite;

    // oscillator sweep, oldest window sample first, later samples win ties
    always_comb begin
        win_v  = win_reg[osc_k_reg];
        hi_upd = osc_first_reg || (win_v >= hi_v_reg);
        lo_upd = osc_first_reg || (win_v <= lo_v_reg);
        hi_a_n = hi_upd ? osc_k_reg : hi_a_reg;
        lo_a_n = lo_upd ? osc_k_reg : lo_a_reg;
        d_w    = 5'(lo_a_n) - 5'(hi_a_n);
        osc_w  = (8'(d_w) <<< 3) + (8'(d_w) <<< 1);
    end

    // walk step: extend the run and keep the furthest right end that passes
    always_comb begin
        rng      = (osc_q_reg < 8'sd50) && (osc_q_reg > -8'sd50);
        rmin_n   = (!in_run_reg || samp_q_reg < run_min_reg) ? samp_q_reg : run_min_reg;
        rmax_n   = (!in_run_reg || samp_q_reg > run_max_reg) ? samp_q_reg : run_max_reg;
        left_n   = in_run_reg ? left_reg : i_reg[ADDR_W-1:0];
        spread_w = {rmax_n[31], rmax_n} - {rmin_n[31], rmin_n};
        five_d   = {3'b000, spread_w} + {1'b0, spread_w, 2'b00};
        cand_ok  = rng && ((i_reg[ADDR_W-1:0] - left_n) >= {2'b00, mr})
                   && (five_d < {3'b000, range_w});
        done_w   = (i_reg + 9'd1) == count_reg;
        closing  = in_run_reg && (!rng || done_w);
        best_ok_n = cand_ok || (in_run_reg && best_ok_reg);
    end

    always_comb begin
        if (state_reg == ST_SC_DIV) begin
            div_sub = {7'd0, range_w} << div_bit_reg;
        end else begin
            div_sub = {31'd0, count_reg} << div_bit_reg;
        end
        div_ge  = div_rem_reg >= div_sub;
        q_final = div_q_reg | {7'd0, div_ge};
        len_w   = best_r_reg - left_reg;
        prod_w  = 15'(score_reg * len_w);
    end

    // memories
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && count_reg < CNT_W'(MAX_LEN)) begin
            sample_mem[count_reg[ADDR_W-1:0]] <= s_data.sample;
        end
        if (state_reg == ST_OSC && osc_k_reg == '0) begin
            osc_mem[wr_idx_reg] <= osc_w;
        end
        if (state_reg == ST_SCAN_RD) begin
            samp_q_reg <= sample_mem[i_reg[ADDR_W-1:0]];
            osc_q_reg  <= osc_mem[i_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && count_reg < CNT_W'(MAX_LEN)) begin
            win_reg[0] <= s_data.sample;
            for (int k = 1; k < WIN_LEN; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_floor_reg <= SPAN_FLOOR_RESET;
        end else if (cfg_wr && paddr[2] == REG_SPAN_FLOOR && paddr[1:0] == 2'b00) begin
            span_floor_reg <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == REG_SPAN_FLOOR) ? {26'd0, span_floor_reg} : 32'd0;
    assign pready = 1'b1;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            seq_min_reg   <= 32'sh7fffffff;
            seq_max_reg   <= 32'sh80000000;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            last_pend_reg <= 1'b0;
            kept_reg      <= '0;
            m_valid_reg   <= 1'b0;
            in_run_reg    <= 1'b0;
            best_ok_reg   <= 1'b0;
            scan_done_reg <= 1'b0;
        end else begin
            // emit states reload the output register themselves
            if (m_valid_reg && m_ready && state_reg != ST_SC_EMIT
                && state_reg != ST_ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        last_pend_reg <= s_data.last_sample;
                        if (count_reg < CNT_W'(MAX_LEN)) begin
                            if (s_data.sample < seq_min_reg) seq_min_reg <= s_data.sample;
                            if (s_data.sample > seq_max_reg) seq_max_reg <= s_data.sample;
                            wr_idx_reg    <= count_reg[ADDR_W-1:0];
                            osc_k_reg     <= (count_reg < 9'd10) ? count_reg[WIN_W-1:0]
                                                                 : WIN_W'(WIN_LEN - 1);
                            osc_first_reg <= 1'b1;
                            count_reg     <= count_reg + 9'd1;
                            state_reg     <= ST_OSC;
                        end else begin
                            ovf_reg <= 1'b1;
                            if (s_data.last_sample) state_reg <= ST_FIN;
                        end
                    end
                end
                ST_OSC: begin
                    osc_first_reg <= 1'b0;
                    if (hi_upd) hi_v_reg <= win_v;
                    if (lo_upd) lo_v_reg <= win_v;
                    hi_a_reg <= hi_a_n;
                    lo_a_reg <= lo_a_n;
                    if (osc_k_reg == '0) begin
                        state_reg <= last_pend_reg ? ST_FIN : ST_IDLE;
                    end else begin
                        osc_k_reg <= osc_k_reg - 4'd1;
                    end
                end
                ST_FIN: begin
                    i_reg         <= '0;
                    in_run_reg    <= 1'b0;
                    best_ok_reg   <= 1'b0;
                    scan_done_reg <= 1'b0;
                    state_reg     <= (count_reg >= {3'b000, mr}) ? ST_SCAN_RD : ST_ST_INIT;
                end
                ST_SCAN_RD: begin
                    state_reg <= ST_SCAN_EV;
                end
                ST_SCAN_EV: begin
                    if (rng) begin
                        run_min_reg <= rmin_n;
                        run_max_reg <= rmax_n;
                        left_reg    <= left_n;
                    end
                    if (cand_ok) begin
                        best_r_reg <= i_reg[ADDR_W-1:0];
                        best_d_reg <= spread_w;
                    end
                    best_ok_reg   <= rng ? best_ok_n : 1'b0;
                    in_run_reg    <= rng;
                    i_reg         <= i_reg + 9'd1;
                    scan_done_reg <= done_w;
                    if ((closing || (rng && done_w)) && best_ok_n) begin
                        state_reg <= ST_SC_INIT;
                    end else if (done_w) begin
                        state_reg <= ST_ST_INIT;
                    end else begin
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SC_INIT: begin
                    // 100*d as shifts and adds
                    div_rem_reg <= {1'b0, best_d_reg, 6'd0} + {2'b00, best_d_reg, 5'd0}
                                 + {5'd0, best_d_reg, 2'd0};
                    div_q_reg   <= '0;
                    div_bit_reg <= 3'd4;
                    best_ok_reg <= 1'b0;
                    state_reg   <= ST_SC_DIV;
                end
                ST_SC_DIV: begin
                    if (div_ge) div_rem_reg <= div_rem_reg - div_sub;
                    div_q_reg[div_bit_reg] <= div_ge;
                    if (div_bit_reg == 3'd0) begin
                        score_reg <= 7'd100 - {2'b00, q_final[4:0]};
                        state_reg <= ST_SC_SUM;
                    end else begin
                        div_bit_reg <= div_bit_reg - 3'd1;
                    end
                end
                ST_SC_SUM: begin
                    sum_reg <= sum_reg + prod_w;
                    if (kept_reg < MAX_KEPT) begin
                        state_reg <= ST_SC_EMIT;
                    end else begin
                        state_reg <= scan_done_reg ? ST_ST_INIT : ST_SCAN_RD;
                    end
                end
                ST_SC_EMIT: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.kind            <= KIND_INTERVAL;
                        m_data_reg.interval_left   <= left_reg;
                        m_data_reg.interval_right  <= best_r_reg;
                        m_data_reg.interval_score  <= score_reg;
                        m_data_reg.interval_group  <= (score_reg >= 7'd100) ? 2'd2
                                                    : (score_reg >= 7'd50) ? 2'd1 : 2'd0;
                        m_data_reg.strength        <= '0;
                        m_data_reg.overflow        <= ovf_reg;
                        m_data_reg.last_result     <= 1'b0;
                        kept_reg  <= kept_reg + 6'd1;
                        state_reg <= scan_done_reg ? ST_ST_INIT : ST_SCAN_RD;
                    end
                end
                ST_ST_INIT: begin
                    div_rem_reg  <= {24'd0, sum_reg, 1'b0};
                    div_q_reg    <= '0;
                    div_bit_reg  <= 3'd7;
                    strength_reg <= '0;
                    state_reg    <= (sum_reg == '0) ? ST_ST_EMIT : ST_ST_DIV;
                end
                ST_ST_DIV: begin
                    if (div_ge) div_rem_reg <= div_rem_reg - div_sub;
                    div_q_reg[div_bit_reg] <= div_ge;
                    if (div_bit_reg == 3'd0) begin
                        strength_reg <= (q_final < 8'd10) ? 8'd10 : q_final;
                        state_reg    <= ST_ST_EMIT;
                    end else begin
                        div_bit_reg <= div_bit_reg - 3'd1;
                    end
                end
                ST_ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.kind            <= KIND_STRENGTH;
                        m_data_reg.interval_left   <= '0;
                        m_data_reg.interval_right  <= '0;
                        m_data_reg.interval_score  <= '0;
                        m_data_reg.interval_group  <= '0;
                        m_data_reg.strength        <= strength_reg;
                        m_data_reg.overflow        <= ovf_reg;
                        m_data_reg.last_result     <= 1'b1;
                        // back to an empty sequence
                        count_reg     <= '0;
                        seq_min_reg   <= 32'sh7fffffff;
                        seq_max_reg   <= 32'sh80000000;
                        sum_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        kept_reg      <= '0;
                        last_pend_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a kept interval always has spread below a fifth of the range
    a_score_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_INTERVAL) |->
        (m_data_reg.interval_score >= 7'd81 && m_data_reg.interval_score <= 7'd100))
        else $error("interval score out of band");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_STRENGTH) |-> m_data_reg.last_result)
        else $error("strength record not flagged last");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("sample count beyond store");

    a_walk_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_RD) |-> (count_reg >= {3'b000, mr} && i_reg < count_reg))
        else $error("walk on short sequence or past end");

endmodule

/* verif/arid_checker.sv */
`timescale 1ns / 100ps
module arid_checker
    import arid_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  arid_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  arid_out_t m_data,
    input  logic [5:0] span_floor,
    output int        fail_count,
    output int        pending
);
    // own copy of the sequence
    logic signed [31:0] samples [MAX_LEN];
    int                 osc_vals [MAX_LEN];
    int                 n_stored;
    longint             seq_lo, seq_hi;
    longint unsigned    score_len_sum;
    logic               ovf;
    arid_out_t          expected_records[$];

    assign pending = expected_records.size();

    function automatic int window_osc(int idx);
        int lo, hp, lp, d, q;
        longint hv, lv;
        lo = (idx >= 10) ? idx - 10 : 0;
        hv = samples[lo];
        lv = samples[lo];
        hp = lo;
        lp = lo;
        for (int j = lo + 1; j <= idx; j++) begin
            if (samples[j] >= hv) begin
                hv = samples[j];
                hp = j;
            end
            if (samples[j] <= lv) begin
                lv = samples[j];
                lp = j;
            end
        end
        d = hp - lp;
        if (d >= 0) return (100 * d) / 10;
        q = (100 * -d) / 10;
        return -q - (((100 * -d) % 10) != 0 ? 1 : 0);
    endfunction

    function automatic bit is_ranging(int idx);
        return osc_vals[idx] < 50 && osc_vals[idx] > -50;
    endfunction

    function automatic longint unsigned spread(int l, int r);
        longint mn, mx;
        mn = samples[l];
        mx = samples[l];
        for (int j = l + 1; j <= r; j++) begin
            if (samples[j] < mn) mn = samples[j];
            if (samples[j] > mx) mx = samples[j];
        end
        return mx - mn;
    endfunction

    function automatic void clear_sequence();
        n_stored = 0;
        seq_lo = 64'sd2147483647;
        seq_hi = -64'sd2147483648;
        score_len_sum = 0;
        ovf = 1'b0;
    endfunction

    task automatic predict_sample(arid_in_t it);
        int unsigned mr, l, r, i, kept;
        longint unsigned rng, d, sc, str;
        arid_out_t rec;
        if (n_stored < MAX_LEN) begin
            samples[n_stored] = it.sample;
            if (it.sample < seq_lo) seq_lo = it.sample;
            if (it.sample > seq_hi) seq_hi = it.sample;
            osc_vals[n_stored] = window_osc(n_stored);
            n_stored++;
        end else begin
            ovf = 1'b1;
        end
        if (!it.last_sample) return;
        mr = (span_floor == 0) ? 1 : span_floor;
        rng = seq_hi - seq_lo;
        kept = 0;
        if (n_stored >= mr) begin
            i = 0;
            while (i < n_stored) begin
                if (!is_ranging(i)) begin
                    i++;
                    continue;
                end
                l = i;
                r = i;
                i++;
                while (i < n_stored && is_ranging(i)) begin
                    r = i;
                    i++;
                end
                // shrink from the right until spread is small enough
                while (r - l >= mr) begin
                    d = spread(l, r);
                    if (rng != 0 && 5 * d < rng) begin
                        sc = 100 - (100 * d) / rng;
                        score_len_sum += sc * (r - l);
                        if (kept < MAX_KEPT) begin
                            rec = '0;
                            rec.kind = KIND_INTERVAL;
                            rec.interval_left = 8'(l);
                            rec.interval_right = 8'(r);
                            rec.interval_score = 7'(sc);
                            rec.interval_group = 2'(sc / 50);
                            rec.overflow = ovf;
                            expected_records.insert(expected_records.size(), rec);
                            kept++;
                        end
                        break;
                    end
                    r--;
                end
                i++;
            end
        end
        str = 0;
        if (score_len_sum > 0 && n_stored > 0) begin
            str = (2 * score_len_sum) / n_stored;
            if (str < 10) str = 10;
        end
        rec = '0;
        rec.kind = KIND_STRENGTH;
        rec.strength = 8'(str);
        rec.overflow = ovf;
        rec.last_result = 1'b1;
        expected_records.insert(expected_records.size(), rec);
        clear_sequence();
    endtask

    task automatic field_check(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        clear_sequence();
    end

    always @(posedge aclk) begin
        arid_out_t e;
        if (aresetn) begin
            if (s_valid && s_ready) predict_sample(s_data);
            if (m_valid && m_ready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    e = expected_records.pop_front();
                    field_check("kind", e.kind, m_data.kind);
                    field_check("interval_left", e.interval_left, m_data.interval_left);
                    field_check("interval_right", e.interval_right, m_data.interval_right);
                    field_check("interval_score", e.interval_score, m_data.interval_score);
                    field_check("interval_group", e.interval_group, m_data.interval_group);
                    field_check("strength", e.strength, m_data.strength);
                    field_check("overflow", e.overflow, m_data.overflow);
                    field_check("last_result", e.last_result, m_data.last_result);
                end
            end
        end
    end
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
module tb
    import arid_pkg::*;
();

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    arid_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    arid_out_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the minimum span for the checker
    logic [5:0]  span_floor_now = SPAN_FLOOR_RESET;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;        // no idling on either side
    bit          hold_off = 1'b0;    // long receiver stall

    always #10 aclk = ~aclk;

    aroon_range_interval_detector i_dut (.*);

    arid_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .span_floor(span_floor_now), .fail_count, .pending
    );

    // watchdog against a hung block
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("aroon_range_interval_detector test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                stall_left = 3000;
                hold_off = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    // apb write, only while idle
    task automatic write_span_floor(logic [5:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_SPAN_FLOOR, 2'b00};
        pwdata <= {26'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        span_floor_now <= val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one sample transfer, with random gap before it; valid stays up after
    // the transfer only until the next sample or a gap takes over
    task automatic send_sample(logic signed [31:0] val, logic is_last);
        while (!calm && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{sample: val, last_sample: is_last};
        items_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value(int mode, logic signed [31:0] base);
        case (mode)
            0: return $urandom;
            1: return base + $signed($urandom_range(40)) - 20;
            default: return $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    // random sequence; mostly wavy values so ranging runs appear
    task automatic send_sequence(int len, int mode);
        logic signed [31:0] base;
        base = $urandom;
        for (int k = 0; k < len; k++) begin
            if (mode == 1 && $urandom_range(9) == 0) base = $urandom;
            send_sample(rand_value(mode, base), k == len - 1);
        end
    endtask

    initial begin
        int len;
        bit pressed;
        pressed = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, flat sequence, short sequence
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh00000000, 1'b0);
        send_sample(32'shffffffff, 1'b1);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b1);
        send_sample(32'sd1, 1'b1);
        // zero range window and flat then step
        drain();
        write_span_floor(6'd0);
        for (int k = 0; k < 10; k++) send_sample(k < 8 ? 32'sd0 : 32'sd1000, k == 9);
        drain();
        // long stretch with no idling on either side
        calm = 1'b1;
        write_span_floor(6'd63);
        send_sequence(80, 1);
        drain();
        calm = 1'b0;
        // overlong sequence
        write_span_floor(6'd2);
        send_sequence(270, 1);
        drain();

        // random phases with several settings
        while (items_sent < 460) begin
            write_span_floor($urandom_range(9) == 0 ? 6'd63 : 6'($urandom_range(1, 8)));
            calm = ($urandom_range(4) == 0);
            if (!pressed) begin
                hold_off = 1'b1;
                pressed = 1'b1;
            end
            for (int s = 0; s < 4; s++) begin
                len = $urandom_range(3) == 0 ? $urandom_range(1, 12) : $urandom_range(20, 40);
                send_sequence(len, $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2));
            end
            drain();
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("aroon_range_interval_detector test passed");
        end else begin
            $display("aroon_range_interval_detector test failed");
        end
        $finish;
    end
endmodule
